// ----- design/dual_ramp_envelope_generator_assert.svh -----
// Assertion macros shared by the envelope generator RTL.
`ifndef DUAL_RAMP_ENVELOPE_GENERATOR_ASSERT_SVH
`define DUAL_RAMP_ENVELOPE_GENERATOR_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define DRENV_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define DRENV_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/drenv_pkg.sv -----
// Types and constants of the dual ramp envelope generator.
`timescale 1ns / 1ps
package drenv_pkg;

  localparam int unsigned DAC_W     = 12;
  localparam int unsigned ACC_W     = 32;
  localparam int unsigned RATE_W    = 28;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned OUT_SHIFT = 18;
  localparam int unsigned WORK_W    = 15;

  localparam logic [ACC_W-1:0]         TOP_LEVEL  = 32'h4000_0000;
  localparam logic signed [WORK_W-1:0] MID_CODE   = 15'sd2047;
  localparam logic signed [WORK_W-1:0] FULL_CODE  = 15'sd4095;
  localparam logic signed [WORK_W-1:0] ABS_OFFSET = -15'sd65;

  // Channel type codes; the unused code behaves as attack-release.
  localparam logic [1:0] KIND_AHR = 2'd0;
  localparam logic [1:0] KIND_OSC = 2'd1;
  localparam logic [1:0] KIND_AR  = 2'd2;

  // Output mode codes; the unused code behaves as normal.
  localparam logic [1:0] OM_NORMAL = 2'd0;
  localparam logic [1:0] OM_INVERT = 2'd1;
  localparam logic [1:0] OM_ABS    = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_TYPE0    = 3'd0;
  localparam logic [2:0] REG_TYPE1    = 3'd1;
  localparam logic [2:0] REG_OUTMODE0 = 3'd2;
  localparam logic [2:0] REG_OUTMODE1 = 3'd3;
  localparam logic [2:0] REG_GAIN0    = 3'd4;
  localparam logic [2:0] REG_GAIN1    = 3'd5;

  typedef enum logic [1:0] {
    EDGE_IDLE    = 2'd0,
    EDGE_RISING  = 2'd1,
    EDGE_HOLDING = 2'd2,
    EDGE_FALLING = 2'd3
  } edge_e;

  typedef enum logic [1:0] {
    RS_IDLE = 2'd0,
    RS_UP   = 2'd1,
    RS_HOLD = 2'd2,
    RS_DOWN = 2'd3
  } ramp_e;

  typedef struct packed {
    logic              channel;
    logic              gate;
    logic [RATE_W-1:0] rise_rate;
    logic [RATE_W-1:0] fall_rate;
  } in_item_t;

  typedef struct packed {
    logic [DAC_W-1:0] dac_value;
    logic [1:0]       ramp_phase;
  } out_item_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [1:0]        outmode;
    logic [GAIN_W-1:0] gain;
  } chan_cfg_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    ramp_e            rs_next;
    ramp_e            rs_cur;
  } ramp_res_t;

endpackage

// ----- design/drenv_ramp.sv -----
// Per-channel gate tracker, ramp state machine and accumulator.
`timescale 1ns / 1ps
module drenv_ramp import drenv_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      adv_i,
  input  in_item_t  item_i,
  input  logic [1:0] kind_i,
  output ramp_res_t res_o
);

  edge_e            edge_q [2];
  ramp_e            rs_q   [2];
  logic [ACC_W-1:0] acc_q  [2];

  edge_e            edge_cur, edge_d;
  ramp_e            rs_cur, rs_d;
  logic [ACC_W-1:0] acc_cur, acc_d, acc_up, acc_dn;
  logic             is_ahr, is_osc, is_env;

  assign edge_cur = edge_q[item_i.channel];
  assign rs_cur   = rs_q[item_i.channel];
  assign acc_cur  = acc_q[item_i.channel];
  assign is_ahr   = (kind_i == KIND_AHR);
  assign is_osc   = (kind_i == KIND_OSC);
  assign is_env   = !is_osc;
  assign acc_up   = acc_cur + {{(ACC_W-RATE_W){1'b0}}, item_i.rise_rate};
  assign acc_dn   = acc_cur - {{(ACC_W-RATE_W){1'b0}}, item_i.fall_rate};

  always_comb begin
    unique case (edge_cur)
      EDGE_IDLE:    edge_d = item_i.gate ? EDGE_RISING : EDGE_IDLE;
      EDGE_RISING:  edge_d = EDGE_HOLDING;
      EDGE_HOLDING: edge_d = item_i.gate ? EDGE_HOLDING : EDGE_FALLING;
      default:      edge_d = EDGE_IDLE;
    endcase
  end

  always_comb begin
    rs_d  = rs_cur;
    acc_d = acc_cur;
    unique case (rs_cur)
      RS_UP: begin
        acc_d = acc_up;
        if (!acc_up[ACC_W-1] && (acc_up > TOP_LEVEL)) begin
          rs_d = is_ahr ? RS_HOLD : RS_DOWN;
        end else if (is_ahr && (edge_d == EDGE_FALLING)) begin
          rs_d = RS_DOWN;
        end
      end
      RS_HOLD: begin
        acc_d = TOP_LEVEL;
        if ((edge_d == EDGE_FALLING) || (edge_d == EDGE_IDLE)) begin
          rs_d = RS_DOWN;
        end
      end
      RS_DOWN: begin
        acc_d = acc_dn;
        if (acc_dn[ACC_W-1]) begin
          rs_d = (is_osc && (edge_d == EDGE_HOLDING)) ? RS_UP : RS_IDLE;
        end else if (is_env && (edge_d == EDGE_RISING)) begin
          rs_d = RS_UP;
        end
      end
      default: begin
        if (edge_d == EDGE_RISING) begin
          rs_d = RS_UP;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        edge_q[i] <= EDGE_IDLE;
        rs_q[i]   <= RS_IDLE;
        acc_q[i]  <= '0;
      end
    end else if (adv_i) begin
      edge_q[item_i.channel] <= edge_d;
      rs_q[item_i.channel]   <= rs_d;
      acc_q[item_i.channel]  <= acc_d;
    end
  end

  assign res_o = '{acc: acc_d, rs_next: rs_d, rs_cur: rs_cur};

endmodule

// ----- design/drenv_shape.sv -----
// Output shaping: scale, oscillator level, invert or absolute, and clamp.
`timescale 1ns / 1ps
module drenv_shape import drenv_pkg::*; (
  input  logic [ACC_W-1:0] acc_i,
  input  chan_cfg_t        cfg_i,
  output logic [DAC_W-1:0] dac_o
);

  logic [DAC_W-1:0]          base;
  logic [DAC_W+GAIN_W-1:0]   prod;
  logic signed [WORK_W-1:0]  lvl, gain_off, v_osc, v_mode;
  logic                      is_osc;

  assign is_osc = (cfg_i.kind == KIND_OSC);

  // Negative accumulator reads as zero; anything at or above 2^30 saturates.
  always_comb begin
    if (acc_i[ACC_W-1]) begin
      base = '0;
    end else if (acc_i[OUT_SHIFT+DAC_W]) begin
      base = '1;
    end else begin
      base = acc_i[OUT_SHIFT +: DAC_W];
    end
  end

  assign prod     = {{GAIN_W{1'b0}}, base} * {{DAC_W{1'b0}}, cfg_i.gain};
  assign lvl      = $signed({{(WORK_W-DAC_W){1'b0}}, prod[GAIN_W +: DAC_W]});
  assign gain_off = MID_CODE - $signed({{(WORK_W-GAIN_W-3){1'b0}}, cfg_i.gain, 3'b000});

  always_comb begin
    if (!is_osc) begin
      v_osc = $signed({{(WORK_W-DAC_W){1'b0}}, base});
    end else if (cfg_i.outmode != OM_ABS) begin
      v_osc = lvl + gain_off;
    end else begin
      v_osc = lvl;
    end
  end

  always_comb begin
    unique case (cfg_i.outmode)
      OM_INVERT: v_mode = FULL_CODE - v_osc;
      OM_ABS:    v_mode = (v_osc >>> 1) + MID_CODE + ABS_OFFSET;
      default:   v_mode = v_osc;
    endcase
  end

  always_comb begin
    if (v_mode < 0) begin
      dac_o = '0;
    end else if (v_mode > FULL_CODE) begin
      dac_o = '1;
    end else begin
      dac_o = v_mode[DAC_W-1:0];
    end
  end

endmodule

// ----- design/dual_ramp_envelope_generator.sv -----
// Top level of the two-channel ramp envelope and oscillator generator.
`timescale 1ns / 1ps
// Each input beat advances one channel (0 or 1) by one sample tick: the gate
// edge tracker steps, the ramp machine adds rise_rate or subtracts fall_rate
// on that channel's 32-bit accumulator (hold pins it at 2^30), and the
// shaped 12-bit sample plus the new ramp phase come out as one result beat.
// The block takes one beat per clock while the output is not stalled: the
// input register feeds a single pass of ramp update, one 12x8 multiply
// and clamps, and the result lands in the output register.
// Channel state is written on the same edge that loads the result, so
// beats for the same channel may follow each other in consecutive cycles.
// A stalled output holds its beat and backs up into the input register;
// in_stall_o rises only once both registers are full. Configuration writes
// are always ready, take effect on the next edge and are meant to be made
// while no beat is in flight; indexes above five are dropped.
module dual_ramp_envelope_generator import drenv_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

`include "dual_ramp_envelope_generator_assert.svh"

  // Configuration registers.
  logic [1:0]        kind_q    [2];
  logic [1:0]        outmode_q [2];
  logic [GAIN_W-1:0] gain_q    [2];

  // Input and result registers.
  logic      in_valid_q, out_valid_q;
  in_item_t  in_q;
  out_item_t out_q;

  logic       adv, in_take;
  chan_cfg_t  chan_cfg;
  ramp_res_t  ramp_res;
  logic [DAC_W-1:0] dac;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 2; i++) begin
        kind_q[i]    <= KIND_AHR;
        outmode_q[i] <= OM_NORMAL;
        gain_q[i]    <= '1;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        REG_TYPE0:    kind_q[0]    <= cfg_data_i[1:0];
        REG_TYPE1:    kind_q[1]    <= cfg_data_i[1:0];
        REG_OUTMODE0: outmode_q[0] <= cfg_data_i[1:0];
        REG_OUTMODE1: outmode_q[1] <= cfg_data_i[1:0];
        REG_GAIN0:    gain_q[0]    <= cfg_data_i[GAIN_W-1:0];
        REG_GAIN1:    gain_q[1]    <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance the input beat whenever the result register is free or draining.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_q <= in_item_i;
    end
  end

  assign chan_cfg = '{kind:    kind_q[in_q.channel],
                      outmode: outmode_q[in_q.channel],
                      gain:    gain_q[in_q.channel]};

  drenv_ramp u_ramp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .item_i (in_q),
    .kind_i (chan_cfg.kind),
    .res_o  (ramp_res)
  );

  drenv_shape u_shape (
    .acc_i (ramp_res.acc),
    .cfg_i (chan_cfg),
    .dac_o (dac)
  );

  // Result register: load on advance, drop once taken downstream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= '{dac_value: dac, ramp_phase: ramp_res.rs_next};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `DRENV_ASSERT_IMP(a_stall_needs_item, in_stall_o, in_valid_q, "input stall without a held beat")
  `DRENV_ASSERT_NXT(a_adv_loads_result, adv, out_valid_q, "advanced beat did not reach output")
  `DRENV_ASSERT_IMP(a_hold_pins_top, adv && (ramp_res.rs_cur == RS_HOLD), ramp_res.acc == TOP_LEVEL, "hold did not pin accumulator")

endmodule
